### rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the IR frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge, disabled while reset is asserted.
`define ACIRFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, also during reset.
`define ACIRFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ACIRFD_ASSERT(lbl, prop, msg)
`define ACIRFD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/core/acirfd_pkg.sv
// Types, codes and constants of the IR frame decoder.
package acirfd_pkg;

  localparam logic [7:0] HdrFirst   = 8'h02;
  localparam logic [7:0] HdrOn      = 8'h92;
  localparam logic [7:0] HdrOff     = 8'hB2;
  localparam logic [7:0] HdrThird   = 8'h0F;
  localparam logic [7:0] B9Mask     = 8'b11111110;
  localparam logic [7:0] CsumLowOn  = 8'h02;
  localparam logic [7:0] CsumLowOff = 8'h22;
  localparam logic [7:0] OffTempRaw = 8'h40;
  localparam int unsigned CsumBase  = 28;

  localparam int unsigned PosW     = 5;
  localparam int unsigned OnesW    = 6;
  localparam int unsigned ShortCnt = 5;

  localparam logic [PosW-1:0] PosSat     = 5'd22;
  localparam logic [PosW-1:0] ShortLen   = 5'd14;
  localparam logic [PosW-1:0] LongLen    = 5'd21;
  localparam logic [PosW-1:0] PosHdr0    = 5'd0;
  localparam logic [PosW-1:0] PosHdr1    = 5'd1;
  localparam logic [PosW-1:0] PosHdr2    = 5'd2;
  localparam logic [PosW-1:0] PosShort0  = 5'd8;
  localparam logic [PosW-1:0] PosSOnes0  = 5'd9;
  localparam logic [PosW-1:0] PosSOnes1  = 5'd12;
  localparam logic [PosW-1:0] PosLCsum   = 5'd15;
  localparam logic [PosW-1:0] PosLOnes0  = 5'd16;
  localparam logic [PosW-1:0] PosLTemp   = 5'd18;
  localparam logic [PosW-1:0] PosLMode   = 5'd19;

  typedef enum logic [2:0] {
    MODE_AUTO    = 3'd0,
    MODE_COOL    = 3'd1,
    MODE_DRY     = 3'd2,
    MODE_FAN     = 3'd3,
    MODE_HEAT    = 3'd4,
    MODE_UNKNOWN = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    FAN_AUTO    = 3'd0,
    FAN_LOW     = 3'd1,
    FAN_MEDIUM  = 3'd2,
    FAN_HIGH    = 3'd3,
    FAN_FOUR    = 3'd4,
    FAN_UNKNOWN = 3'd5
  } fan_e;

  typedef enum logic [1:0] {
    SW_ON      = 2'd0,
    SW_OFF     = 2'd1,
    SW_UNKNOWN = 2'd2
  } switch_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       frame_ok;
    logic       long_form;
    logic       power_on;
    logic [2:0] mode;
    logic [4:0] temperature;
    logic [2:0] fan_speed;
    logic [1:0] airflow;
    logic [1:0] turbo;
    logic [7:0] checksum_expected;
    logic [7:0] checksum_received;
    logic       checksum_match;
  } out_item_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [7:0] sum_byte(input logic [OnesW-1:0] ones,
                                          input logic [7:0] low);
    logic [OnesW-1:0] diff;
    diff = OnesW'(CsumBase) - ones;
    return {diff[3:0], 4'h0} | low;
  endfunction

endpackage

### rtl/core/acirfd_if.sv
// Valid/ready channel interfaces for the decoder's input bytes and results.
interface acirfd_in_if;
  logic                 valid;
  logic                 ready;
  acirfd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface acirfd_out_if;
  logic                  valid;
  logic                  ready;
  acirfd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/ac_ir_frame_decoder.sv
// A result is on out_o in the cycle after the transfer of the last byte of a frame.
// Throughput: one byte per cycle; a result held on out_o by a low ready stalls in_i.
// Per cycle: byte popcount, frame decode and checksum between state and result registers.
// Reset: all frame state and the result valid flag clear; state also clears after a last byte.
// A new frame may start in the cycle after a last byte.
`include "assert_macros.svh"

module ac_ir_frame_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  acirfd_in_if.sink           in_i,
  acirfd_out_if.source        out_o
);

  localparam int unsigned PosW  = acirfd_pkg::PosW;
  localparam int unsigned OnesW = acirfd_pkg::OnesW;
  localparam int unsigned NShort = acirfd_pkg::ShortCnt;

  logic [PosW-1:0]  pos_q, pos_d;
  logic             hdr0_q, hdr0_d;
  logic [7:0]       hdr1_q, hdr1_d;
  logic             hdr2_q, hdr2_d;
  logic [7:0]       sbytes_q [NShort];
  logic [7:0]       sbytes_d [NShort];
  logic [7:0]       lcsum_q, lcsum_d;
  logic [7:0]       ltemp_q, ltemp_d;
  logic [7:0]       lmode_q, lmode_d;
  logic [OnesW-1:0] sones_q, sones_d;
  logic [OnesW-1:0] lones_q, lones_d;

  logic                  res_valid_q, res_valid_d;
  acirfd_pkg::out_item_t res_q, res_d;

  logic       in_xfer;
  logic       out_xfer;
  logic [7:0] b;
  logic       last;

  assign b        = in_i.payload.data_byte;
  assign last     = in_i.payload.last_byte;
  assign in_i.ready = !res_valid_q || out_o.ready;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = res_valid_q && out_o.ready;

  assign out_o.valid   = res_valid_q;
  assign out_o.payload = res_q;

  // Frame state after taking in the current byte
  logic [PosW-1:0]  u_pos;
  logic             u_hdr0, u_hdr2;
  logic [7:0]       u_hdr1;
  logic [7:0]       u_sb [NShort];
  logic [7:0]       u_lcsum, u_ltemp, u_lmode;
  logic [OnesW-1:0] u_sones, u_lones;

  always_comb begin
    u_hdr0  = (pos_q == acirfd_pkg::PosHdr0) ? (b == acirfd_pkg::HdrFirst) : hdr0_q;
    u_hdr1  = (pos_q == acirfd_pkg::PosHdr1) ? b : hdr1_q;
    u_hdr2  = (pos_q == acirfd_pkg::PosHdr2) ? (b == acirfd_pkg::HdrThird) : hdr2_q;
    for (int k = 0; k < NShort; k++) begin
      u_sb[k] = (pos_q == acirfd_pkg::PosShort0 + PosW'(k)) ? b : sbytes_q[k];
    end
    u_lcsum = (pos_q == acirfd_pkg::PosLCsum) ? b : lcsum_q;
    u_ltemp = (pos_q == acirfd_pkg::PosLTemp) ? b : ltemp_q;
    u_lmode = (pos_q == acirfd_pkg::PosLMode) ? b : lmode_q;
    u_sones = sones_q;
    if (pos_q == acirfd_pkg::PosSOnes0) begin
      u_sones = sones_q + OnesW'(acirfd_pkg::ones8(b & acirfd_pkg::B9Mask));
    end else if (pos_q > acirfd_pkg::PosSOnes0 && pos_q <= acirfd_pkg::PosSOnes1) begin
      u_sones = sones_q + OnesW'(acirfd_pkg::ones8(b));
    end
    u_lones = lones_q;
    if (pos_q >= acirfd_pkg::PosLOnes0 && pos_q <= acirfd_pkg::PosLMode) begin
      u_lones = lones_q + OnesW'(acirfd_pkg::ones8(b));
    end
    u_pos = (pos_q < acirfd_pkg::PosSat) ? pos_q + PosW'(1) : pos_q;
  end

  // Frame decode
  logic       hdr_ok, is_short, is_long, off;
  logic [3:0] s_hi, s_lo, l_hi, l_lo;
  logic [7:0] s_exp, l_exp;
  acirfd_pkg::mode_e   s_mode, l_mode;
  acirfd_pkg::fan_e    s_fan, l_fan;
  acirfd_pkg::switch_e s_air, s_turbo;

  always_comb begin
    hdr_ok   = u_hdr0 && u_hdr2;
    is_short = hdr_ok && (u_pos == acirfd_pkg::ShortLen) && (u_hdr1 == acirfd_pkg::HdrOn);
    is_long  = hdr_ok && (u_pos == acirfd_pkg::LongLen) &&
               (u_hdr1 == acirfd_pkg::HdrOn || u_hdr1 == acirfd_pkg::HdrOff);
    off      = (u_hdr1 == acirfd_pkg::HdrOff);
    s_hi = u_sb[4][7:4];
    s_lo = u_sb[4][3:0];
    l_hi = u_lmode[7:4];
    l_lo = u_lmode[3:0];

    unique case (s_hi)
      4'h0:    s_mode = acirfd_pkg::MODE_AUTO;
      4'h1:    s_mode = acirfd_pkg::MODE_COOL;
      4'h2:    s_mode = acirfd_pkg::MODE_DRY;
      4'h3:    s_mode = acirfd_pkg::MODE_FAN;
      4'h4:    s_mode = acirfd_pkg::MODE_HEAT;
      default: s_mode = acirfd_pkg::MODE_UNKNOWN;
    endcase

    unique case (l_hi)
      4'h0:    l_mode = acirfd_pkg::MODE_AUTO;
      4'h1:    l_mode = acirfd_pkg::MODE_COOL;
      4'h2:    l_mode = acirfd_pkg::MODE_DRY;
      4'h4:    l_mode = acirfd_pkg::MODE_HEAT;
      default: l_mode = acirfd_pkg::MODE_UNKNOWN;
    endcase

    unique case (s_lo)
      4'h1:    s_fan = acirfd_pkg::FAN_AUTO;
      4'h5:    s_fan = acirfd_pkg::FAN_LOW;
      4'h9:    s_fan = acirfd_pkg::FAN_MEDIUM;
      4'hB:    s_fan = acirfd_pkg::FAN_HIGH;
      4'hF:    s_fan = acirfd_pkg::FAN_FOUR;
      default: s_fan = acirfd_pkg::FAN_UNKNOWN;
    endcase

    unique case (l_lo) inside
      4'h1, 4'hD: l_fan = acirfd_pkg::FAN_AUTO;
      4'h5:       l_fan = acirfd_pkg::FAN_LOW;
      4'h9:       l_fan = acirfd_pkg::FAN_MEDIUM;
      4'hB:       l_fan = acirfd_pkg::FAN_HIGH;
      default:    l_fan = acirfd_pkg::FAN_UNKNOWN;
    endcase

    unique case (u_sb[1][7:4])
      4'hA:    s_air = acirfd_pkg::SW_ON;
      4'hF:    s_air = acirfd_pkg::SW_OFF;
      default: s_air = acirfd_pkg::SW_UNKNOWN;
    endcase

    unique case (u_sb[2][3:0])
      4'h7:    s_turbo = acirfd_pkg::SW_ON;
      4'h1:    s_turbo = acirfd_pkg::SW_OFF;
      default: s_turbo = acirfd_pkg::SW_UNKNOWN;
    endcase

    s_exp = acirfd_pkg::sum_byte(u_sones, acirfd_pkg::CsumLowOn);
    l_exp = acirfd_pkg::sum_byte(u_lones,
                                 off ? acirfd_pkg::CsumLowOff : acirfd_pkg::CsumLowOn);
    // power-off frame with the fixed temperature byte in cool, dry or heat
    if (off && u_ltemp == acirfd_pkg::OffTempRaw &&
        (l_hi == 4'(acirfd_pkg::MODE_HEAT) || l_hi == 4'(acirfd_pkg::MODE_DRY) ||
         l_hi == 4'(acirfd_pkg::MODE_COOL))) begin
      l_exp = acirfd_pkg::CsumLowOn;
    end

    res_d = '0;
    if (is_short) begin
      res_d.frame_ok          = 1'b1;
      res_d.long_form         = 1'b0;
      res_d.power_on          = 1'b1;
      res_d.mode              = s_mode;
      res_d.temperature       = 5'(u_sb[3][7:4]) + 5'd16;
      res_d.fan_speed         = s_fan;
      res_d.airflow           = s_air;
      res_d.turbo             = s_turbo;
      res_d.checksum_expected = s_exp;
      res_d.checksum_received = u_sb[0];
      res_d.checksum_match    = (s_exp == u_sb[0]);
    end else if (is_long) begin
      res_d.frame_ok          = 1'b1;
      res_d.long_form         = 1'b1;
      res_d.power_on          = !off;
      res_d.mode              = l_mode;
      res_d.temperature       = 5'(u_ltemp[7:4]) + 5'd16;
      res_d.fan_speed         = l_fan;
      res_d.airflow           = acirfd_pkg::SW_UNKNOWN;
      res_d.turbo             = acirfd_pkg::SW_UNKNOWN;
      res_d.checksum_expected = l_exp;
      res_d.checksum_received = u_lcsum;
      res_d.checksum_match    = (l_exp == u_lcsum);
    end
  end

  // Next state: take the byte, or clear the frame state after the last one
  always_comb begin
    pos_d    = pos_q;
    hdr0_d   = hdr0_q;
    hdr1_d   = hdr1_q;
    hdr2_d   = hdr2_q;
    sbytes_d = sbytes_q;
    lcsum_d  = lcsum_q;
    ltemp_d  = ltemp_q;
    lmode_d  = lmode_q;
    sones_d  = sones_q;
    lones_d  = lones_q;
    if (in_xfer) begin
      if (last) begin
        pos_d   = '0;
        hdr0_d  = 1'b0;
        hdr1_d  = '0;
        hdr2_d  = 1'b0;
        for (int k = 0; k < NShort; k++) begin
          sbytes_d[k] = '0;
        end
        lcsum_d = '0;
        ltemp_d = '0;
        lmode_d = '0;
        sones_d = '0;
        lones_d = '0;
      end else begin
        pos_d    = u_pos;
        hdr0_d   = u_hdr0;
        hdr1_d   = u_hdr1;
        hdr2_d   = u_hdr2;
        sbytes_d = u_sb;
        lcsum_d  = u_lcsum;
        ltemp_d  = u_ltemp;
        lmode_d  = u_lmode;
        sones_d  = u_sones;
        lones_d  = u_lones;
      end
    end
    res_valid_d = res_valid_q;
    if (in_xfer && last) begin
      res_valid_d = 1'b1;
    end else if (out_xfer) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr0_q      <= 1'b0;
      hdr1_q      <= '0;
      hdr2_q      <= 1'b0;
      for (int k = 0; k < NShort; k++) begin
        sbytes_q[k] <= '0;
      end
      lcsum_q     <= '0;
      ltemp_q     <= '0;
      lmode_q     <= '0;
      sones_q     <= '0;
      lones_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hdr0_q      <= hdr0_d;
      hdr1_q      <= hdr1_d;
      hdr2_q      <= hdr2_d;
      sbytes_q    <= sbytes_d;
      lcsum_q     <= lcsum_d;
      ltemp_q     <= ltemp_d;
      lmode_q     <= lmode_d;
      sones_q     <= sones_d;
      lones_q     <= lones_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last) begin
      res_q <= res_d;
    end
  end

  `ACIRFD_ASSERT(a_clear_after_last, (in_xfer && last) |=> (pos_q == '0 && sones_q == '0 && lones_q == '0), "frame state not cleared after last byte")
  `ACIRFD_ASSERT(a_pos_advance, (in_xfer && !last && pos_q < acirfd_pkg::PosSat) |=> (pos_q == $past(pos_q) + PosW'(1)), "byte position did not advance")
  `ACIRFD_ASSERT(a_result_source, $rose(res_valid_q) |-> $past(in_xfer && last), "result without a last byte")
  `ACIRFD_ASSERT(a_bad_frame_zero, (res_valid_q && !res_q.frame_ok) |-> (res_q.checksum_expected == '0 && res_q.temperature == '0 && res_q.mode == '0), "rejected frame with nonzero fields")
  `ACIRFD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!res_valid_q && pos_q == '0), "state not cleared in reset")

endmodule
